@@ hw/rtl/pwbr_pkg.sv @@
// pwbr_pkg: shared types and constants of the pulse width bus receiver
// no dependencies; imported by the event and config interfaces, the top level and the testbench

package pwbr_pkg;

  // tick counter and nibble buffer sizing
  localparam int unsigned CountWidth  = 8;
  localparam int unsigned MaxNibbles  = 64;
  localparam int unsigned NibCntWidth = $clog2(MaxNibbles + 1);
  localparam int unsigned PosWidth    = 6;
  localparam int unsigned TotalWidth  = 7;
  localparam int unsigned CfgWidth    = 8;
  localparam int unsigned CfgIdxWidth = 3;

  // nibble assembly: bits per nibble, nibble count that a packet must exceed to report an end
  localparam int unsigned NibbleBits  = 4;
  localparam int unsigned MinPacket   = 2;

  typedef logic [CountWidth-1:0]  tick_t;
  typedef logic [NibCntWidth-1:0] nib_cnt_t;
  typedef logic [CfgWidth-1:0]    cfg_t;
  typedef logic [CfgIdxWidth-1:0] cfg_idx_t;
  typedef logic [3:0]             nibble_t;

  // register indexes of the configuration channel
  localparam cfg_idx_t CFG_ZERO_MIN = 3'd0;
  localparam cfg_idx_t CFG_ZERO_MAX = 3'd1;
  localparam cfg_idx_t CFG_ONE_MIN  = 3'd2;
  localparam cfg_idx_t CFG_ONE_MAX  = 3'd3;
  localparam cfg_idx_t CFG_TIMEOUT  = 3'd4;

  // register reset values
  localparam cfg_t ZeroMinReset = 8'd10;
  localparam cfg_t ZeroMaxReset = 8'd30;
  localparam cfg_t OneMinReset  = 8'd40;
  localparam cfg_t OneMaxReset  = 8'd70;
  localparam cfg_t TimeoutReset = 8'd100;

  typedef enum logic [1:0] {
    EV_NIBBLE = 2'd0,
    EV_END    = 2'd1,
    EV_ABORT  = 2'd2
  } event_kind_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PULSE = 2'd1,
    PH_GAP   = 2'd2
  } phase_e;

endpackage

@@ hw/rtl/pwbr_if.sv @@
// pwbr channel interfaces: line sample input, event output, config write
// depends on pwbr_pkg

interface pwbr_in_if;
  logic valid;
  logic ready;
  logic line_active;

  modport source (output valid, output line_active, input ready);
  modport sink   (input valid, input line_active, output ready);
endinterface

interface pwbr_out_if
  import pwbr_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [1:0]            event_kind;
  logic [3:0]            nibble_value;
  logic                  nibble_bad;
  logic [PosWidth-1:0]   nibble_position;
  logic [TotalWidth-1:0] packet_nibbles;
  logic                  buffer_overflow;

  modport source (output valid, output event_kind, output nibble_value, output nibble_bad,
                  output nibble_position, output packet_nibbles, output buffer_overflow,
                  input ready);
  modport sink   (input valid, input event_kind, input nibble_value, input nibble_bad,
                  input nibble_position, input packet_nibbles, input buffer_overflow,
                  output ready);
endinterface

interface pwbr_cfg_if
  import pwbr_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [CfgIdxWidth-1:0] index;
  logic [CfgWidth-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/pulse_width_bus_receiver_top.sv @@
// pulse width bus receiver: bit decoder, nibble packer and packet end detection
// depends on pwbr_pkg and the channel interfaces in pwbr_if.sv
// latency: an event is valid on the output the cycle after its sample beat
// throughput: one line sample per cycle; the output register lets a new
//   beat in whenever it is empty or being drained in the same cycle
// reset: asynchronous, active low; decoder idle, config registers at their defaults, output valid low

module pulse_width_bus_receiver_top
  import pwbr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  pwbr_in_if.sink    in_i,
  pwbr_cfg_if.sink   cfg_i,
  pwbr_out_if.source out_o
);

  // configuration registers
  cfg_t zero_min_q, zero_max_q, one_min_q, one_max_q, timeout_q;

  // decoder state
  phase_e   phase_q, phase_d;
  logic     prev_q, prev_d;
  tick_t    tick_q, tick_d;
  logic [1:0] slot_q, slot_d;
  nibble_t  shift_q, shift_d;
  logic     err_q, err_d;
  nib_cnt_t count_q, count_d;

  // output register
  logic                  out_valid_q, out_valid_d;
  event_kind_e           kind_q, kind_d;
  nibble_t               value_q, value_d;
  logic                  bad_q, bad_d;
  logic [PosWidth-1:0]   pos_q, pos_d;
  logic [TotalWidth-1:0] total_q, total_d;
  logic                  ovf_q, ovf_d;

  logic     accept;
  logic     rising, falling;
  tick_t    tick_inc;
  logic     bit_val, bit_bad;
  nibble_t  shift_new;
  logic     err_new;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign accept      = in_i.valid && in_i.ready;

  // config writes; indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_min_q <= ZeroMinReset;
      zero_max_q <= ZeroMaxReset;
      one_min_q  <= OneMinReset;
      one_max_q  <= OneMaxReset;
      timeout_q  <= TimeoutReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_ZERO_MIN: zero_min_q <= cfg_i.data;
        CFG_ZERO_MAX: zero_max_q <= cfg_i.data;
        CFG_ONE_MIN:  one_min_q  <= cfg_i.data;
        CFG_ONE_MAX:  one_max_q  <= cfg_i.data;
        CFG_TIMEOUT:  timeout_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // edge detect and saturating tick count
  assign rising   = in_i.line_active && !prev_q;
  assign falling  = !in_i.line_active && prev_q;
  assign tick_inc = (tick_q == {CountWidth{1'b1}}) ? tick_q : tick_q + tick_t'(1);

  // pulse length classification
  always_comb begin
    bit_val = 1'b0;
    bit_bad = 1'b0;
    if (tick_inc < zero_min_q) begin
      bit_bad = 1'b1;
    end else if (tick_inc <= zero_max_q) begin
      bit_val = 1'b0;
    end else if (tick_inc < one_min_q) begin
      bit_bad = 1'b1;
    end else if (tick_inc <= one_max_q) begin
      bit_val = 1'b1;
    end else begin
      bit_bad = 1'b1;
    end
  end

  assign shift_new = {shift_q[NibbleBits-2:0], bit_val};
  assign err_new   = err_q | bit_bad;

  // next state and event for one sample beat
  always_comb begin
    phase_d     = phase_q;
    prev_d      = prev_q;
    tick_d      = tick_q;
    slot_d      = slot_q;
    shift_d     = shift_q;
    err_d       = err_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_o.ready;
    kind_d      = kind_q;
    value_d     = value_q;
    bad_d       = bad_q;
    pos_d       = pos_q;
    total_d     = total_q;
    ovf_d       = ovf_q;

    if (accept) begin
      prev_d = in_i.line_active;
      tick_d = tick_inc;
      kind_d  = EV_NIBBLE;
      value_d = '0;
      bad_d   = 1'b0;
      pos_d   = '0;
      total_d = '0;
      ovf_d   = 1'b0;

      if (rising && phase_q != PH_PULSE) begin
        // pulse start; a new packet clears the nibble in progress
        if (phase_q == PH_IDLE) begin
          slot_d  = '0;
          shift_d = '0;
          err_d   = 1'b0;
        end
        tick_d  = '0;
        phase_d = PH_PULSE;
      end else if (falling && phase_q == PH_PULSE) begin
        // pulse end: shift in the bit, emit on the fourth
        phase_d = PH_GAP;
        slot_d  = slot_q + 2'd1;
        shift_d = shift_new;
        err_d   = err_new;
        if (slot_q == 2'(NibbleBits - 1)) begin
          out_valid_d = 1'b1;
          value_d     = shift_new;
          bad_d       = err_new;
          shift_d     = '0;
          err_d       = 1'b0;
          if (count_q >= nib_cnt_t'(MaxNibbles)) begin
            ovf_d = 1'b1;
          end else begin
            pos_d   = count_q[PosWidth-1:0];
            count_d = count_q + nib_cnt_t'(1);
          end
        end
      end else if (phase_q != PH_IDLE && tick_inc >= timeout_q) begin
        // packet timeout: report abort on a partial nibble or end if long enough, then clear
        phase_d = PH_IDLE;
        total_d = TotalWidth'(count_q);
        if (slot_q != '0) begin
          out_valid_d = 1'b1;
          kind_d      = EV_ABORT;
        end else if (count_q > nib_cnt_t'(MinPacket)) begin
          out_valid_d = 1'b1;
          kind_d      = EV_END;
        end
        count_d = '0;
        slot_d  = '0;
        shift_d = '0;
        err_d   = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      prev_q      <= 1'b0;
      tick_q      <= '0;
      slot_q      <= '0;
      shift_q     <= '0;
      err_q       <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      prev_q      <= prev_d;
      tick_q      <= tick_d;
      slot_q      <= slot_d;
      shift_q     <= shift_d;
      err_q       <= err_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    value_q <= value_d;
    bad_q   <= bad_d;
    pos_q   <= pos_d;
    total_q <= total_d;
    ovf_q   <= ovf_d;
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.event_kind      = kind_q;
  assign out_o.nibble_value    = value_q;
  assign out_o.nibble_bad      = bad_q;
  assign out_o.nibble_position = pos_q;
  assign out_o.packet_nibbles  = total_q;
  assign out_o.buffer_overflow = ovf_q;

endmodule

@@ dv/tb_pulse_width_bus_receiver_top.sv @@
// testbench for pulse_width_bus_receiver_top: line sample streams in, decoded events checked
// depends on pwbr_pkg, the channel interfaces in pwbr_if.sv and the top level rtl
// self-checking against a local decoder model; prints one pass or fail line at the end

module tb_pulse_width_bus_receiver_top;
  import pwbr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit    = 4000;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned LongHold      = 300;
  localparam int unsigned LongHoldAfter = 900;
  localparam int unsigned RandPhases    = 4;
  localparam int unsigned PhaseLines    = 20;
  localparam int unsigned OvfNibbles    = MaxNibbles + 2;

  typedef struct packed {
    event_kind_e           kind;
    nibble_t               value;
    logic                  bad;
    logic [PosWidth-1:0]   pos;
    logic [TotalWidth-1:0] total;
    logic                  ovf;
  } nib_event_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pwbr_in_if  in_if ();
  pwbr_out_if out_if ();
  pwbr_cfg_if cfg_if ();

  pulse_width_bus_receiver_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  always #2 clk_i = ~clk_i;

  // line samples waiting to be sent, events waiting to be seen
  logic        sample_q [$];
  nib_event_t  pending_events [$];

  int unsigned lines_queued;
  int unsigned lines_in;
  int unsigned mismatches;
  int unsigned stall_cycles;
  int unsigned send_gap;
  int unsigned hold_left;
  bit          long_hold_done;
  bit          burst_mode;

  // decoder model state and its copy of the threshold registers
  cfg_t        thr [5];
  phase_e      ph;
  logic        prev_lvl;
  tick_t       ticks;
  logic [1:0]  slot;
  nibble_t     shreg;
  logic        nib_err;
  nib_cnt_t    nib_cnt;

  function automatic void reset_decoder();
    thr[CFG_ZERO_MIN] = ZeroMinReset;
    thr[CFG_ZERO_MAX] = ZeroMaxReset;
    thr[CFG_ONE_MIN]  = OneMinReset;
    thr[CFG_ONE_MAX]  = OneMaxReset;
    thr[CFG_TIMEOUT]  = TimeoutReset;
    ph       = PH_IDLE;
    prev_lvl = 1'b0;
    ticks    = '0;
    slot     = '0;
    shreg    = '0;
    nib_err  = 1'b0;
    nib_cnt  = '0;
  endfunction

  // one line sample through the decoder; queues the event it causes, if any
  function automatic void decode_sample(logic level);
    nib_event_t ev;
    logic       rise;
    logic       fall;
    logic       bitv;
    logic       badv;
    rise     = level && !prev_lvl;
    fall     = !level && prev_lvl;
    prev_lvl = level;
    ev       = '0;
    if (ticks != '1) ticks = ticks + 1'b1;

    if (rise && ph != PH_PULSE) begin
      if (ph == PH_IDLE) begin
        slot    = '0;
        shreg   = '0;
        nib_err = 1'b0;
      end
      ticks = '0;
      ph    = PH_PULSE;
    end else if (fall && ph == PH_PULSE) begin
      // sort the pulse length into zero, one or out of range
      bitv = 1'b0;
      badv = 1'b0;
      if (ticks < thr[CFG_ZERO_MIN]) badv = 1'b1;
      else if (ticks <= thr[CFG_ZERO_MAX]) bitv = 1'b0;
      else if (ticks < thr[CFG_ONE_MIN]) badv = 1'b1;
      else if (ticks <= thr[CFG_ONE_MAX]) bitv = 1'b1;
      else badv = 1'b1;
      ph      = PH_GAP;
      shreg   = {shreg[2:0], bitv};
      nib_err = nib_err | badv;
      slot    = slot + 1'b1;
      if (slot == '0) begin
        ev.kind  = EV_NIBBLE;
        ev.value = shreg;
        ev.bad   = nib_err;
        if (nib_cnt >= MaxNibbles) begin
          ev.ovf = 1'b1;
        end else begin
          ev.pos  = nib_cnt[PosWidth-1:0];
          nib_cnt = nib_cnt + 1'b1;
        end
        pending_events.push_back(ev);
        shreg   = '0;
        nib_err = 1'b0;
      end
    end else if (ph != PH_IDLE && ticks >= thr[CFG_TIMEOUT]) begin
      // packet timeout: abort on a partial nibble, end if long enough
      ph       = PH_IDLE;
      ev.total = nib_cnt;
      if (slot != '0) begin
        ev.kind = EV_ABORT;
        pending_events.push_back(ev);
      end else if (nib_cnt > MinPacket) begin
        ev.kind = EV_END;
        pending_events.push_back(ev);
      end
      nib_cnt = '0;
      slot    = '0;
      shreg   = '0;
      nib_err = 1'b0;
    end
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  function automatic void check_event();
    nib_event_t want;
    if (pending_events.size() == 0) begin
      mismatches++;
      $display("%0t ns: event kind %0d with nothing expected", $time, out_if.event_kind);
    end else begin
      want = pending_events.pop_front();
      compare_field("event_kind", want.kind, out_if.event_kind);
      compare_field("nibble_value", want.value, out_if.nibble_value);
      compare_field("nibble_bad", want.bad, out_if.nibble_bad);
      compare_field("nibble_position", want.pos, out_if.nibble_position);
      compare_field("packet_nibbles", want.total, out_if.packet_nibbles);
      compare_field("buffer_overflow", want.ovf, out_if.buffer_overflow);
    end
  endfunction

  // mostly no gap, sometimes a short one, rarely a long one; never a gap in burst mode
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // pulse length aimed at a zero, a one, or one of the out of range bands
  function automatic int unsigned pulse_len(int unsigned bad_pct);
    int unsigned r;
    int unsigned len;
    r = $urandom_range(0, 99);
    if (r < bad_pct) begin
      case ($urandom_range(0, 2))
        0: len = (thr[CFG_ZERO_MIN] > 1) ? $urandom_range(1, thr[CFG_ZERO_MIN] - 1) : 1;
        1: len = $urandom_range(thr[CFG_ZERO_MAX] + 1, thr[CFG_ONE_MIN]);
        default: len = thr[CFG_ONE_MAX] + $urandom_range(1, 4);
      endcase
    end else if (r[0]) begin
      len = $urandom_range(thr[CFG_ZERO_MIN], thr[CFG_ZERO_MAX]);
    end else begin
      len = $urandom_range(thr[CFG_ONE_MIN], thr[CFG_ONE_MAX]);
    end
    return (len == 0) ? 1 : len;
  endfunction

  task automatic push_level(logic level, int unsigned n);
    repeat (n) sample_q.push_back(level);
    lines_queued += n;
  endtask

  task automatic queue_pulse(int unsigned len, int unsigned gap);
    push_level(1'b1, len);
    push_level(1'b0, gap);
  endtask

  // well-formed packet with random bits, sometimes cut mid-nibble or broken
  task automatic queue_random_packet();
    int unsigned tmo;
    int unsigned nib;
    int unsigned nbits;
    int unsigned len;
    int unsigned gap;
    int unsigned r;
    tmo = thr[CFG_TIMEOUT];
    r   = $urandom_range(0, 9);
    if (tmo > 40) nib = 0;
    else if (r < 2) nib = $urandom_range(0, 2);
    else if (r < 9) nib = $urandom_range(3, 6);
    else nib = $urandom_range(8, 20);
    nbits = nib * NibbleBits;
    if ($urandom_range(0, 4) == 0) nbits += $urandom_range(1, NibbleBits - 1);
    push_level(1'b0, $urandom_range(1, 3));
    for (int b = 0; b < nbits; b++) begin
      len = pulse_len(10);
      if (len >= tmo && tmo > 1 && $urandom_range(0, 19) != 0) len = tmo - 1;
      gap = (tmo > len + 1) ? $urandom_range(1, tmo - len) : 1;
      if ($urandom_range(0, 29) == 0) gap = tmo + 1;
      queue_pulse(len, gap);
    end
    push_level(1'b0, tmo + $urandom_range(0, 3));
  endtask

  task automatic queue_noise();
    repeat ($urandom_range(4, 20)) push_level(1'($urandom_range(0, 1)), $urandom_range(1, 8));
  endtask

  // wait until every sample is in and every event is out, then let the pipe settle
  task automatic wait_drained();
    do @(posedge clk_i);
    while (sample_q.size() != 0 || in_if.valid || lines_in != lines_queued ||
           pending_events.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_t val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i);
    while (!cfg_if.ready);
    thr[idx] = val;
  endtask

  task automatic apply_config(cfg_t z0, cfg_t z1, cfg_t o0, cfg_t o1, cfg_t tmo);
    write_reg(CFG_ZERO_MIN, z0);
    write_reg(CFG_ZERO_MAX, z1);
    write_reg(CFG_ONE_MIN, o0);
    write_reg(CFG_ONE_MAX, o1);
    write_reg(CFG_TIMEOUT, tmo);
    cfg_if.valid <= 1'b0;
  endtask

  // sample driver: one line sample per beat, random gaps between beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid       <= 1'b0;
      in_if.line_active <= 1'b0;
      send_gap          <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        decode_sample(in_if.line_active);
        lines_in++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_gap != 0) begin
          in_if.valid <= 1'b0;
          send_gap    <= send_gap - 1;
        end else if (sample_q.size() != 0) begin
          in_if.valid       <= 1'b1;
          in_if.line_active <= sample_q.pop_front();
          send_gap          <= idle_len();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // event monitor: checks each beat, stalls at random, one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready   <= 1'b0;
      hold_left      <= 0;
      long_hold_done <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) check_event();
      if (hold_left != 0) begin
        out_if.ready <= 1'b0;
        hold_left    <= hold_left - 1;
      end else if (!long_hold_done && out_if.valid && lines_in > LongHoldAfter) begin
        out_if.ready   <= 1'b0;
        hold_left      <= LongHold;
        long_hold_done <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
        hold_left    <= (out_if.valid && out_if.ready) ? idle_len() : 0;
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == StallLimit) begin
      $display("%0t ns: no beat for %0d cycles", $time, StallLimit);
      $display("tb_pulse_width_bus_receiver_top failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // stimulus sequence
  initial begin
    int unsigned set_dflt [12] = '{10, 30, 40, 70, 9, 31, 39, 71, 1, 2, 20, 3};
    int unsigned set_bad  [6]  = '{1, 4, 7, 2, 3, 5};
    int unsigned set_good [12] = '{2, 5, 3, 6, 6, 6, 2, 2, 5, 3, 6, 2};
    int unsigned z0;
    int unsigned z1;
    int unsigned o0;
    int unsigned o1;
    int unsigned tm;
    int unsigned phase_start;

    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.line_active = 1'b0;
    out_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = CFG_ZERO_MIN;
    cfg_if.data       = '0;
    lines_queued      = 0;
    lines_in          = 0;
    mismatches        = 0;
    burst_mode        = 1'b0;
    reset_decoder();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset thresholds: every band edge and its outside neighbor, ends with three nibbles
    push_level(1'b0, 2);
    foreach (set_dflt[i]) queue_pulse(set_dflt[i], 2);
    push_level(1'b0, 105);
    wait_drained();

    // small thresholds: bad bits then abort, short packet, pulse held over timeout, lone bit then abort
    apply_config(2, 3, 5, 6, 12);
    foreach (set_bad[i]) queue_pulse(set_bad[i], 2);
    push_level(1'b0, 14);
    for (int i = 0; i < 8; i++) queue_pulse(set_good[i], 2);
    push_level(1'b0, 14);
    foreach (set_good[i]) queue_pulse(set_good[i], 3);
    push_level(1'b1, 20);
    push_level(1'b0, 14);
    queue_pulse(3, 14);
    wait_drained();

    // tiny thresholds: packet past the buffer size, then a short one from position 0
    apply_config(1, 1, 2, 2, 3);
    push_level(1'b0, 1);
    for (int b = 0; b < OvfNibbles * NibbleBits; b++) queue_pulse($urandom_range(1, 2), 1);
    push_level(1'b0, 5);
    for (int b = 0; b < 3 * NibbleBits; b++) queue_pulse($urandom_range(1, 2), 1);
    push_level(1'b0, 5);
    wait_drained();

    // random phases: extremes first, then arbitrary and ordered thresholds
    for (int p = 0; p < RandPhases; p++) begin
      if (p == 0) begin
        apply_config(0, 0, 0, 0, 1);
      end else if (p == 1) begin
        apply_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      end else if (p == 2) begin
        apply_config(cfg_t'($urandom_range(0, 255)), cfg_t'($urandom_range(0, 255)),
                     cfg_t'($urandom_range(0, 255)), cfg_t'($urandom_range(0, 255)),
                     cfg_t'($urandom_range(1, 40)));
      end else begin
        z0 = $urandom_range(0, 4);
        z1 = z0 + $urandom_range(0, 3);
        o0 = z1 + $urandom_range(1, 3);
        o1 = o0 + $urandom_range(0, 3);
        tm = o1 + $urandom_range(1, 8);
        apply_config(cfg_t'(z0), cfg_t'(z1), cfg_t'(o0), cfg_t'(o1), cfg_t'(tm));
      end
      burst_mode  = (p % 3 == 2);
      phase_start = lines_queued;
      while (lines_queued - phase_start < PhaseLines) begin
        if ($urandom_range(0, 9) == 0) queue_noise();
        else queue_random_packet();
        if ($urandom_range(0, 7) == 0) wait_drained();
      end
      wait_drained();
    end

    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("tb_pulse_width_bus_receiver_top passed");
    end else begin
      if (pending_events.size() != 0)
        $display("%0t ns: %0d events never arrived", $time, pending_events.size());
      $display("tb_pulse_width_bus_receiver_top failed");
    end
    $finish;
  end

endmodule
